>>> rtl/core/a64x_pkg.sv
// a64x_pkg: shared types, constants and the instruction decoder for the
// arm64 subset executor. No dependencies; imported by rtl/core but a64x_ram.
package a64x_pkg;

    // data memory geometry
    localparam int DMEM_WORDS = 4096;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);

    // register file geometry
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam int XLEN = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_MEM_BYTES  = 2'd0;
    localparam logic [1:0] CFG_STACK_BASE = 2'd1;
    localparam logic [1:0] CFG_ENTRY_PC   = 2'd2;

    localparam logic [15:0] MEM_BYTES_RST = 16'd32768;

    // result status codes
    localparam logic [1:0] ST_CONT    = 2'd0;
    localparam logic [1:0] ST_RET     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_SVC     = 2'd3;

    // encodings
    localparam logic [31:0] RET_WORD  = 32'hD65F03C0;
    localparam logic [31:0] RET_MASK  = 32'hFFFFFC00;
    localparam logic [31:0] RET_MATCH = 32'hD65F0000;
    localparam logic [31:0] MOVZ_MASK = 32'hFFC00000;
    localparam logic [31:0] MOVZ_MATCH = 32'hD2800000;
    localparam logic [31:0] ADDSUB_MASK = 32'h7F000000;
    localparam logic [31:0] ADD_MATCH = 32'h11000000;
    localparam logic [31:0] SUB_MATCH = 32'h51000000;
    localparam logic [31:0] LDST_MASK = 32'hFFC003E0;
    localparam logic [31:0] STR_MATCH = 32'hF80003E0;
    localparam logic [31:0] LDR_MATCH = 32'hF94003E0;
    localparam logic [31:0] SVC_MASK  = 32'hFFFF0000;
    localparam logic [31:0] SVC_MATCH = 32'hD4000000;

    localparam logic [RF_AW-1:0] REG_CALL_NUM = RF_AW'(8);
    localparam logic [RF_AW-1:0] REG_CALL_ARG = RF_AW'(0);

    typedef enum logic [2:0] {
        OP_RET,
        OP_MOVZ,
        OP_ADD,
        OP_SUB,
        OP_STR,
        OP_LDR,
        OP_SVC,
        OP_UNK
    } t_op;

    // register file write port
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [XLEN-1:0]  data;
    } t_rf_wr;

    // data memory write port
    typedef struct packed {
        logic               en;
        logic [DMEM_AW-1:0] addr;
        logic [XLEN-1:0]    data;
    } t_dm_wr;

    // first match wins
    function automatic t_op a64x_decode(input logic [31:0] w);
        t_op op;
        priority if ((w & RET_MASK) == RET_MATCH)      op = OP_RET;
        else if ((w & MOVZ_MASK) == MOVZ_MATCH)        op = OP_MOVZ;
        else if ((w & ADDSUB_MASK) == ADD_MATCH)       op = OP_ADD;
        else if ((w & ADDSUB_MASK) == SUB_MATCH)       op = OP_SUB;
        else if ((w & LDST_MASK) == STR_MATCH)         op = OP_STR;
        else if ((w & LDST_MASK) == LDR_MATCH)         op = OP_LDR;
        else if ((w & SVC_MASK) == SVC_MATCH)          op = OP_SVC;
        else                                           op = OP_UNK;
        return op;
    endfunction

endpackage

>>> rtl/core/a64x_ram.sv
// a64x_ram: generic single-write, single-read synchronous RAM with a
// registered read port (old data on a same-address write). No dependencies.
module a64x_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/a64x_regs.sv
// a64x_regs: 32 x 64 general register file, two read ports, one write port.
// Uses a64x_ram (one copy per read port) and a64x_pkg.
module a64x_regs
    import a64x_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [RF_AW-1:0] i_rd_addr_a,
    input  logic [RF_AW-1:0] i_rd_addr_b,
    output logic [XLEN-1:0]  o_rd_data_a,
    output logic [XLEN-1:0]  o_rd_data_b,
    input  t_rf_wr           i_wr
);

    logic [RF_DEPTH-1:0] r_vld;
    logic                r_vld_a, r_vld_b;
    logic                r_hit_a, r_hit_b;
    logic [XLEN-1:0]     r_byp;
    logic [XLEN-1:0]     ram_a, ram_b;

    a64x_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_a),
        .o_rdata (ram_a)
    );

    a64x_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_b),
        .o_rdata (ram_b)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // write landing on the same edge as the read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_vld_a <= r_vld[i_rd_addr_a];
            r_vld_b <= r_vld[i_rd_addr_b];
            r_hit_a <= i_wr.en && (i_wr.addr == i_rd_addr_a);
            r_hit_b <= i_wr.en && (i_wr.addr == i_rd_addr_b);
            r_byp   <= i_wr.data;
        end
    end

    assign o_rd_data_a = r_hit_a ? r_byp : (r_vld_a ? ram_a : '0);
    assign o_rd_data_b = r_hit_b ? r_byp : (r_vld_b ? ram_b : '0);

endmodule

>>> rtl/core/a64x_dmem.sv
// a64x_dmem: data memory of DMEM_WORDS x 64 with a zeroing sweep after reset
// and same-edge write forwarding. Uses a64x_ram and a64x_pkg.
module a64x_dmem
    import a64x_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [DMEM_AW-1:0] i_rd_addr,
    output logic [XLEN-1:0]    o_rd_data,
    input  t_dm_wr             i_wr,
    output logic               o_busy
);

    logic               r_busy;
    logic [DMEM_AW-1:0] r_clr_addr;
    logic               r_hit;
    logic [XLEN-1:0]    r_byp;
    logic [XLEN-1:0]    ram_q;
    t_dm_wr             wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + DMEM_AW'(1);
            if (r_clr_addr == DMEM_AW'(DMEM_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_busy) begin
            wr.en   = 1'b1;
            wr.addr = r_clr_addr;
            wr.data = '0;
        end else begin
            wr = i_wr;
        end
    end

    a64x_ram #(.WIDTH(XLEN), .DEPTH(DMEM_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_hit <= wr.en && (wr.addr == i_rd_addr);
            r_byp <= wr.data;
        end
    end

    assign o_rd_data = r_hit ? r_byp : ram_q;
    assign o_busy    = r_busy;

endmodule

>>> rtl/core/arm64_subset_executor_unit.sv
// arm64_subset_executor_unit: top level of the arm64 subset executor.
// Uses a64x_pkg, a64x_regs, a64x_dmem (and a64x_ram through them).
//
// One 32-bit instruction word per item goes in, one result item comes out:
// status, next_pc, call_number, call_arg. Feed each word from the next_pc of
// the previous result (or entry_pc after reset / a config write). The unit
// takes one item per cycle unless the output stalls or the sweep runs; an
// item waits in stage 1 until the output register is free. Stage 0 decodes the
// word and launches register-file and data-memory reads, stage 1 takes the read
// data (with forwarding of the write made by the item just ahead) and does
// the single read-modify-write of the register file or data memory, then
// loads the output register. After reset the data memory is swept to zero,
// one word a cycle, all DMEM_WORDS (4096) words; s_axis_tready stays low
// during that sweep while configuration writes are still taken. Write
// configuration only while no item is in flight.
module arm64_subset_executor_unit
    import a64x_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    // instruction items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] instruction
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata    // [1:0] status, [65:2] next_pc,
                                         // [129:66] call_number,
                                         // [193:130] call_arg, rest zero
);

    // configuration
    logic [15:0]     r_mem_bytes;
    logic [14:0]     r_stack_base;
    logic [XLEN-1:0] r_pc;

    // stage 0 decode
    logic               in_acc;
    logic               fetch_oob;
    t_op                s0_op;
    logic [RF_AW-1:0]   s0_rd, s0_rn;
    logic [11:0]        s0_imm12;
    logic [15:0]        s0_addr;
    logic               s0_ok;
    logic [RF_AW-1:0]   s0_ra;
    logic [DMEM_AW-1:0] s0_widx;
    logic [XLEN-1:0]    n_pc;

    // stage 1
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [RF_AW-1:0]   r_s1_rd;
    logic [11:0]        r_s1_imm12;
    logic [15:0]        r_s1_imm16;
    logic               r_s1_ok;
    logic [DMEM_AW-1:0] r_s1_widx;
    logic [XLEN-1:0]    r_s1_pc;
    logic               s1_adv;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [XLEN-1:0]    r_out_pc;
    logic [XLEN-1:0]    r_out_cn;
    logic [XLEN-1:0]    r_out_ca;

    logic [XLEN-1:0]    rf_a, rf_b, dm_q;
    logic               dm_busy;
    t_rf_wr             rf_wr;
    t_dm_wr             dm_wr;
    logic [1:0]         s1_status;
    logic [XLEN-1:0]    s1_cn, s1_ca;

    // handshake: the output register parts the two sides
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !dm_busy && (!r_s1_valid || !r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // fetch bound: pc must leave room for a whole word
    always_comb begin
        if (r_mem_bytes < 16'd4) begin
            fetch_oob = 1'b1;
        end else begin
            fetch_oob = (r_pc[XLEN-1:16] != '0) || (r_pc[15:0] > (r_mem_bytes - 16'd4));
        end
    end

    assign s0_op    = a64x_decode(fetch_oob ? RET_WORD : s_axis_tdata);
    assign s0_rd    = s_axis_tdata[4:0];
    assign s0_rn    = s_axis_tdata[9:5];
    assign s0_imm12 = s_axis_tdata[21:10];

    // stack base plus scaled offset, 16 bits cannot overflow
    assign s0_addr  = {1'b0, r_stack_base} + {1'b0, s0_imm12, 3'b000};
    assign s0_ok    = (({1'b0, s0_addr} + 17'd8) <= {1'b0, r_mem_bytes})
                   && (32'(s0_addr[15:3]) < 32'(DMEM_WORDS));
    assign s0_widx  = DMEM_AW'(s0_addr[15:3]);

    // port a: rn for add/sub, rt for store, x8 for a syscall; port b: x0
    always_comb begin
        unique case (s0_op)
            OP_SVC:  s0_ra = REG_CALL_NUM;
            OP_STR:  s0_ra = s0_rd;
            default: s0_ra = s0_rn;
        endcase
    end

    assign n_pc = r_pc + XLEN'(4);

    // config registers and program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_bytes  <= MEM_BYTES_RST;
            r_stack_base <= '0;
            r_pc         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEM_BYTES:  r_mem_bytes  <= i_cfg_data;
                    CFG_STACK_BASE: r_stack_base <= i_cfg_data[14:0];
                    CFG_ENTRY_PC:   r_pc         <= XLEN'(i_cfg_data[14:0]);
                    default:        ;
                endcase
            end else if (in_acc) begin
                r_pc <= n_pc;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= s0_op;
            r_s1_rd    <= s0_rd;
            r_s1_imm12 <= s0_imm12;
            r_s1_imm16 <= s_axis_tdata[20:5];
            r_s1_ok    <= s0_ok;
            r_s1_widx  <= s0_widx;
            r_s1_pc    <= n_pc;
        end
    end

    a64x_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (s0_ra),
        .i_rd_addr_b (REG_CALL_ARG),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b),
        .i_wr        (rf_wr)
    );

    a64x_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (s0_widx),
        .o_rd_data (dm_q),
        .i_wr      (dm_wr),
        .o_busy    (dm_busy)
    );

    // stage 1: execute and write back
    always_comb begin
        rf_wr.en   = 1'b0;
        rf_wr.addr = r_s1_rd;
        rf_wr.data = '0;
        dm_wr.en   = 1'b0;
        dm_wr.addr = r_s1_widx;
        dm_wr.data = rf_a;
        s1_status  = ST_CONT;
        s1_cn      = '0;
        s1_ca      = '0;
        unique case (r_s1_op)
            OP_RET: begin
                s1_status = ST_RET;
            end
            OP_MOVZ: begin
                rf_wr.en   = s1_adv;
                rf_wr.data = XLEN'(r_s1_imm16);
            end
            OP_ADD: begin
                rf_wr.en   = s1_adv;
                rf_wr.data = rf_a + XLEN'(r_s1_imm12);
            end
            OP_SUB: begin
                rf_wr.en   = s1_adv;
                rf_wr.data = rf_a - XLEN'(r_s1_imm12);
            end
            OP_STR: begin
                dm_wr.en = s1_adv && r_s1_ok;
            end
            OP_LDR: begin
                rf_wr.en   = s1_adv && r_s1_ok;
                rf_wr.data = dm_q;
            end
            OP_SVC: begin
                s1_status = ST_SVC;
                s1_cn     = rf_a;
                s1_ca     = rf_b;
            end
            default: begin
                s1_status = ST_UNKNOWN;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= s1_status;
            r_out_pc     <= r_s1_pc;
            r_out_cn     <= s1_cn;
            r_out_ca     <= s1_ca;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_ca, r_out_cn, r_out_pc, r_out_status};

    // no item enters while the memory sweep runs
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_busy |-> !in_acc)
        else $error("item accepted during data memory sweep");

    // an accepted item always occupies stage 1 next cycle
    a_s1_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item lost before stage 1");

    // a stage-1 item that cannot advance keeps the input stalled
    a_s1_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !s_axis_tready)
        else $error("input taken while stage 1 is blocked");

    // only a syscall result carries register values
    a_call_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_SVC)) |-> (r_out_cn == '0 && r_out_ca == '0))
        else $error("call fields set on a non-syscall result");

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for arm64_subset_executor_unit, which runs a small
// aarch64 subset one instruction word per item and returns one result item per word.
// Depends on a64x_pkg and the unit's rtl; directed table first, then random programs.
module tb;
    import a64x_pkg::*;

    // one retired instruction as the unit reports it
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] next_pc;
        logic [63:0] call_num;
        logic [63:0] call_arg;
    } t_retire;

    // directed table row: either a config write or an instruction item
    typedef struct {
        logic        is_cfg;
        logic [1:0]  cfg_idx;
        logic [31:0] value;
        logic        typed;
        t_retire     res;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [31:0] instruction
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;   // [1:0] status, [65:2] next_pc, [129:66] call_number,
                                  // [193:130] call_arg, rest zero

    // architectural state mirrored by the predictor
    logic [63:0] pc_m;
    logic [63:0] gpr_m [RF_DEPTH];
    logic [63:0] dmem_m [DMEM_WORDS];
    logic [15:0] mem_bytes_m;
    logic [14:0] stack_base_m;

    t_retire retire_q [$];   // results still owed by the unit, oldest first
    int      mismatch_cnt = 0;
    int      result_cnt = 0;
    logic    tx_burst = 1'b0; // sender runs without gaps while set

    arm64_subset_executor_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous bound on the whole run, including the memory sweep after reset
    initial begin
        #3_000_000;
        $display("** arm64_subset_executor_unit: FAILED **");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // executes one word against the mirrored state and returns what must retire
    function automatic t_retire execute_word(input logic [31:0] word);
        t_retire     r;
        logic [31:0] w;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [11:0] imm12;
        logic [63:0] addr;
        logic        acc_ok;
        r     = '0;
        w     = word;
        rd    = word[4:0];
        rn    = word[9:5];
        imm12 = word[21:10];
        // fetch outside the memory in use behaves as a return
        if (mem_bytes_m < 16'd4 || pc_m > 64'(mem_bytes_m) - 64'd4)
            w = RET_WORD;
        pc_m   = pc_m + 64'd4;
        // byte address keeps the unaligned base, the word select drops the low bits
        addr   = 64'(stack_base_m) + (64'(imm12) << 3);
        acc_ok = (addr + 64'd8 <= 64'(mem_bytes_m)) && ((addr >> 3) < 64'(DMEM_WORDS));
        if ((w & RET_MASK) == RET_MATCH) begin
            r.status = ST_RET;
        end else if ((w & MOVZ_MASK) == MOVZ_MATCH) begin
            gpr_m[rd] = 64'(w[20:5]);
        end else if ((w & ADDSUB_MASK) == ADD_MATCH) begin
            gpr_m[rd] = gpr_m[rn] + 64'(imm12);
        end else if ((w & ADDSUB_MASK) == SUB_MATCH) begin
            gpr_m[rd] = gpr_m[rn] - 64'(imm12);
        end else if ((w & LDST_MASK) == STR_MATCH) begin
            if (acc_ok)
                dmem_m[addr[DMEM_AW+2:3]] = gpr_m[rd];
        end else if ((w & LDST_MASK) == LDR_MATCH) begin
            if (acc_ok)
                gpr_m[rd] = dmem_m[addr[DMEM_AW+2:3]];
        end else if ((w & SVC_MASK) == SVC_MATCH) begin
            r.status   = ST_SVC;
            r.call_num = gpr_m[REG_CALL_NUM];
            r.call_arg = gpr_m[REG_CALL_ARG];
        end else begin
            r.status = ST_UNKNOWN;
        end
        r.next_pc = pc_m;
        return r;
    endfunction

    // register choice leans on a few registers so values flow between instructions
    function automatic logic [4:0] pick_reg();
        int k;
        k = $urandom_range(0, 13);
        if (k > 10)
            return 5'($urandom);
        return (k == 10) ? 5'd31 : 5'(k);
    endfunction

    // random instruction word: mostly well-formed, some pure noise
    function automatic logic [31:0] gen_word();
        int          pick;
        t_op         op;
        logic [31:0] w;
        logic [11:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 5)       op = OP_RET;
        else if (pick < 22) op = OP_MOVZ;
        else if (pick < 40) op = OP_ADD;
        else if (pick < 55) op = OP_SUB;
        else if (pick < 70) op = OP_STR;
        else if (pick < 85) op = OP_LDR;
        else if (pick < 90) op = OP_SVC;
        else                op = OP_UNK;
        // stack offsets mostly near the base, sometimes anywhere
        off = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
        w   = $urandom;
        case (op)
            OP_RET:  w = RET_MATCH | (w & ~RET_MASK);
            OP_MOVZ: w = MOVZ_MATCH | (w & ~MOVZ_MASK & ~32'h1F) | 32'(pick_reg());
            OP_ADD:  w = ADD_MATCH | (w & ~ADDSUB_MASK & ~32'h3FF)
                         | (32'(pick_reg()) << 5) | 32'(pick_reg());
            OP_SUB:  w = SUB_MATCH | (w & ~ADDSUB_MASK & ~32'h3FF)
                         | (32'(pick_reg()) << 5) | 32'(pick_reg());
            OP_STR:  w = STR_MATCH | (32'(off) << 10) | 32'(pick_reg());
            OP_LDR:  w = LDR_MATCH | (32'(off) << 10) | 32'(pick_reg());
            OP_SVC:  w = SVC_MATCH | (w & ~SVC_MASK);
            default: ;
        endcase
        return w;
    endfunction

    // register write, mirrored at the edge that takes it
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_MEM_BYTES:  mem_bytes_m = v;
            CFG_STACK_BASE: stack_base_m = v[14:0];
            CFG_ENTRY_PC:   pc_m = 64'(v[14:0]);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and let every owed result drain, plus the pipeline depth
    task automatic wait_idle();
        int n;
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (retire_q.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // one instruction item; a typed result replaces the prediction when given
    task automatic send_word(input logic [31:0] w, input logic use_typed,
                             input t_retire typed_r);
        int      gap;
        t_retire r;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = execute_word(w);
        retire_q.push_back(use_typed ? typed_r : r);
    endtask

    function automatic t_dir_row item_row(input logic [31:0] w);
        t_dir_row row;
        row = '{1'b0, CFG_MEM_BYTES, w, 1'b0, t_retire'('0)};
        return row;
    endfunction

    function automatic t_dir_row typed_row(input logic [31:0] w, input logic [1:0] st,
                                           input logic [63:0] npc, input logic [63:0] num,
                                           input logic [63:0] arg);
        t_dir_row row;
        row = '{1'b0, CFG_MEM_BYTES, w, 1'b1, t_retire'({st, npc, num, arg})};
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [1:0] idx, input logic [15:0] v);
        t_dir_row row;
        row = '{1'b1, idx, 32'(v), 1'b0, t_retire'('0)};
        return row;
    endfunction

    // result side: random stalls, checks every result against the oldest owed one
    initial begin : result_sink
        int      stall;
        logic    rx_burst;
        t_retire got;
        t_retire want;
        rx_burst = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            // occasional stretches with tready held high
            if ($urandom_range(0, 40) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.status   = m_axis_tdata[1:0];
            got.next_pc  = m_axis_tdata[65:2];
            got.call_num = m_axis_tdata[129:66];
            got.call_arg = m_axis_tdata[193:130];
            if (retire_q.size() == 0) begin
                flag_mismatch("result with nothing owed, status", 64'(got.status), 64'd0);
            end else begin
                want = retire_q.pop_front();
                if (got.status != want.status)
                    flag_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.next_pc != want.next_pc)
                    flag_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.call_num != want.call_num)
                    flag_mismatch("call_number", got.call_num, want.call_num);
                if (got.call_arg != want.call_arg)
                    flag_mismatch("call_arg", got.call_arg, want.call_arg);
            end
            result_cnt++;
        end
    end

    // stimulus: reset, directed table, then random programs between config changes
    initial begin : stim
        t_dir_row    dir_tab [$];
        int          rand_items;
        int          n_items;
        int          sel;
        logic [31:0] w;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MEM_BYTES;
        i_cfg_data    <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // predictor state after reset
        pc_m         = 64'd0;
        mem_bytes_m  = MEM_BYTES_RST;
        stack_base_m = 15'd0;
        for (int i = 0; i < RF_DEPTH; i++)
            gpr_m[i] = 64'd0;
        for (int i = 0; i < DMEM_WORDS; i++)
            dmem_m[i] = 64'd0;

        // return, x0 = 0xffff, x8 = 93, then a syscall carrying both
        dir_tab.push_back(typed_row(RET_WORD, ST_RET, 64'd4, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hD29FFFE0, ST_CONT, 64'd8, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hD2800BA8, ST_CONT, 64'd12, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hD4000000, ST_SVC, 64'd16, 64'd93, 64'd65535));
        // wrapping sub and add, size and shift bits set, register 31 as source and dest
        dir_tab.push_back(item_row(32'h51000421));
        dir_tab.push_back(item_row(32'h113FFC22));
        dir_tab.push_back(item_row(32'h91C0001F));
        dir_tab.push_back(item_row(32'hD13FFFFE));
        // store at offset zero and at the last word, load both back
        dir_tab.push_back(item_row(32'hF80003E1));
        dir_tab.push_back(item_row(32'hF83FFFFE));
        dir_tab.push_back(item_row(32'hF97FFFE3));
        dir_tab.push_back(item_row(32'hF94003E4));
        dir_tab.push_back(typed_row(32'hD400FFFF, ST_SVC, 64'd52, 64'd93, 64'd65535));
        // unknown words: all zero, all one, store pattern with a wrong base field
        dir_tab.push_back(typed_row(32'h00000000, ST_UNKNOWN, 64'd56, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hFFFFFFFF, ST_UNKNOWN, 64'd60, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hF8000000, ST_UNKNOWN, 64'd64, 64'd0, 64'd0));
        // unaligned stack base
        dir_tab.push_back(cfg_row(CFG_STACK_BASE, 16'd3));
        dir_tab.push_back(item_row(32'hF80007E2));
        dir_tab.push_back(item_row(32'hF94007E5));
        // tiny memory: store past the end dropped, load inside kept, fetch past the end
        dir_tab.push_back(cfg_row(CFG_MEM_BYTES, 16'd16));
        dir_tab.push_back(cfg_row(CFG_ENTRY_PC, 16'd0));
        dir_tab.push_back(item_row(32'hF80007E2));
        dir_tab.push_back(item_row(32'hF94003E6));
        dir_tab.push_back(item_row(32'h110004C7));
        dir_tab.push_back(item_row(32'hD4000000));
        dir_tab.push_back(typed_row(32'hD2800009, ST_RET, 64'd20, 64'd0, 64'd0));
        // no memory at all
        dir_tab.push_back(cfg_row(CFG_MEM_BYTES, 16'd0));
        dir_tab.push_back(typed_row(32'hD4000000, ST_RET, 64'd24, 64'd0, 64'd0));
        // top of the range: base and entry at their maximum
        dir_tab.push_back(cfg_row(CFG_MEM_BYTES, MEM_BYTES_RST));
        dir_tab.push_back(cfg_row(CFG_STACK_BASE, 16'd32767));
        dir_tab.push_back(cfg_row(CFG_ENTRY_PC, 16'd32767));
        dir_tab.push_back(typed_row(32'hF80003E1, ST_RET, 64'd32771, 64'd0, 64'd0));
        dir_tab.push_back(cfg_row(CFG_ENTRY_PC, 16'd32764));
        dir_tab.push_back(typed_row(32'hF80003E1, ST_CONT, 64'd32768, 64'd0, 64'd0));
        dir_tab.push_back(typed_row(32'hF94003EA, ST_RET, 64'd32772, 64'd0, 64'd0));

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                wait_idle();
                write_cfg(dir_tab[k].cfg_idx, dir_tab[k].value[15:0]);
            end else begin
                send_word(dir_tab[k].value, dir_tab[k].typed, dir_tab[k].res);
            end
        end

        // random programs; every word sent counts toward the total
        rand_items = 0;
        while (rand_items < 1150) begin
            wait_idle();
            tx_burst = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 11);
            if (sel == 0)
                write_cfg(CFG_MEM_BYTES, 16'($urandom_range(0, 32768)));
            else if (sel == 1)
                write_cfg(CFG_MEM_BYTES, 16'd0);
            else if (sel == 2)
                write_cfg(CFG_MEM_BYTES, 16'($urandom_range(4, 96)));
            else
                write_cfg(CFG_MEM_BYTES, MEM_BYTES_RST);
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    write_cfg(CFG_STACK_BASE, 16'($urandom_range(0, 32767)));
                else
                    write_cfg(CFG_STACK_BASE, 16'($urandom_range(0, 4095) << 3));
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
                write_cfg(CFG_ENTRY_PC, 16'($urandom_range(0, 32767)));
            else if (sel == 1)
                write_cfg(CFG_ENTRY_PC, 16'(32768 - 4 * $urandom_range(1, 16)));
            else
                write_cfg(CFG_ENTRY_PC, 16'($urandom_range(0, 2047) << 2));
            n_items = $urandom_range(4, 60);
            for (int i = 0; i < n_items; i++) begin
                rand_items++;
                w = gen_word();
                send_word(w, 1'b0, t_retire'('0));
            end
        end

        wait_idle();
        if (retire_q.size() != 0)
            flag_mismatch("results never delivered", 64'(retire_q.size()), 64'd0);
        if (mismatch_cnt == 0) begin
            $display("** arm64_subset_executor_unit: PASSED **");
        end else begin
            $display("** arm64_subset_executor_unit: FAILED **");
        end
        $finish;
    end

endmodule
